// ----- sv/cpmc_pkg.sv -----
package cpmc_pkg;

	localparam int WHEEL_COUNT = 3;
	localparam int ADC_WIDTH = 12;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_INDEX_W = 3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MEAS_MUL,
		ST_MEAS,
		ST_P_MUL,
		ST_I_MUL,
		ST_FIN
	} state_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SPEED_KP = 3'd0,
		REG_SPEED_KI = 3'd1,
		REG_CURRENT_KP = 3'd2,
		REG_CURRENT_KI = 3'd3,
		REG_SPEED_SCALE = 3'd4,
		REG_ADC_ZERO_CODE = 3'd5,
		REG_ADC_AMPS_PER_CODE = 3'd6,
		REG_PWM_PERIOD = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic load;
		logic mul_meas;
		logic meas;
		logic mul_p;
		logic mul_i;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic bad_wheel;
	} status_t;

endpackage

// ----- sv/cascaded_pi_motor_controller_top.sv -----
// Cascaded PI speed/current controller for three wheels, signed Q12.12.
// A speed request (action 0) measures speed from the encoder count and updates
// the wheel's current set point; a current request (action 1) measures current
// from the ADC code and produces the forward/reverse PWM compare values. One
// request is processed at a time: a valid wheel steps through ST_MEAS_MUL,
// ST_MEAS, ST_P_MUL, ST_I_MUL and ST_FIN, and an out-of-range wheel goes from
// ST_MEAS_MUL straight to ST_FIN. The single shared 33x17 multiplier is used
// three times per valid request. The controller returns to idle on the edge
// that registers the result, and ST_FIN waits while an earlier result is still
// not taken. The result sits in an output register, so the next request is
// accepted while it waits. Gains and scales are written through the cfg port
// while no request is in flight; the block itself does not enforce this.
module cascaded_pi_motor_controller_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [cpmc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [cpmc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             action,
	input  logic [1:0]                       wheel_index,
	input  logic signed [23:0]               target_speed,
	input  logic [15:0]                      encoder_count,
	input  logic                             counting_down,
	input  logic [11:0]                      adc_sample,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [1:0]                       out_wheel,
	output logic signed [23:0]               measured_speed,
	output logic signed [23:0]               current_setpoint,
	output logic signed [23:0]               measured_current,
	output logic [15:0]                      duty_forward,
	output logic [15:0]                      duty_reverse
);
	import cpmc_pkg::*;

	cmd_t    cmd;
	status_t status;

	cpmc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	cpmc_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.action           (action),
		.wheel_index      (wheel_index),
		.target_speed     (target_speed),
		.encoder_count    (encoder_count),
		.counting_down    (counting_down),
		.adc_sample       (adc_sample),
		.out_wheel        (out_wheel),
		.measured_speed   (measured_speed),
		.current_setpoint (current_setpoint),
		.measured_current (measured_current),
		.duty_forward     (duty_forward),
		.duty_reverse     (duty_reverse)
	);

endmodule

// ----- sv/cpmc_ctrl.sv -----
module cpmc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  cpmc_pkg::status_t status,
	output cpmc_pkg::cmd_t    cmd
);
	import cpmc_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   fin_go;

	assign fin_go = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_MEAS_MUL;
			end
			ST_MEAS_MUL: begin
				state_d = status.bad_wheel ? ST_FIN : ST_MEAS;
			end
			ST_MEAS:  state_d = ST_P_MUL;
			ST_P_MUL: state_d = ST_I_MUL;
			ST_I_MUL: state_d = ST_FIN;
			ST_FIN: begin
				if (fin_go) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:     cmd.load = in_valid;
			ST_MEAS_MUL: cmd.mul_meas = 1'b1;
			ST_MEAS:     cmd.meas = 1'b1;
			ST_P_MUL:    cmd.mul_p = 1'b1;
			ST_I_MUL:    cmd.mul_i = 1'b1;
			ST_FIN:      cmd.fin = fin_go;
			default:     cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fin_go) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ----- sv/cpmc_datapath.sv -----
module cpmc_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cpmc_pkg::cmd_t                       cmd,
	output cpmc_pkg::status_t                    status,
	input  logic                                 cfg_we,
	input  logic [cpmc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [cpmc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 action,
	input  logic [1:0]                           wheel_index,
	input  logic signed [23:0]                   target_speed,
	input  logic [15:0]                          encoder_count,
	input  logic                                 counting_down,
	input  logic [11:0]                          adc_sample,
	output logic [1:0]                           out_wheel,
	output logic signed [23:0]                   measured_speed,
	output logic signed [23:0]                   current_setpoint,
	output logic signed [23:0]                   measured_current,
	output logic [15:0]                          duty_forward,
	output logic [15:0]                          duty_reverse
);
	import cpmc_pkg::*;

	// config
	logic [15:0] speed_kp_q, speed_ki_q, current_kp_q, current_ki_q;
	logic [15:0] speed_scale_q, adc_amps_q, pwm_period_q;
	logic [ADC_WIDTH-1:0] adc_zero_q;

	// latched request
	logic                 action_q;
	logic [1:0]           wheel_q;
	logic signed [23:0]   target_q;
	logic [15:0]          count_q;
	logic                 down_q;
	logic [ADC_WIDTH-1:0] code_q;

	// per-wheel state
	logic signed [31:0] spd_int_q [WHEEL_COUNT];
	logic signed [31:0] cur_int_q [WHEEL_COUNT];
	logic signed [23:0] setpt_q [WHEEL_COUNT];
	logic [15:0]        duty_fwd_q [WHEEL_COUNT];
	logic [15:0]        duty_rev_q [WHEEL_COUNT];

	// shared multiplier
	logic signed [32:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [49:0] mul_p;
	logic signed [49:0] prod_q, acc_q;

	logic signed [24:0] err_q;
	logic signed [31:0] integ_q;
	logic signed [23:0] meas_q;

	logic               bad;
	logic signed [ADC_WIDTH:0] adc_diff;

	assign bad = (int'(wheel_q) >= WHEEL_COUNT);
	assign status.bad_wheel = bad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_kp_q <= 16'd256;
			speed_ki_q <= 16'd0;
			current_kp_q <= 16'd256;
			current_ki_q <= 16'd0;
			speed_scale_q <= 16'd4096;
			adc_zero_q <= ADC_WIDTH'(2048);
			adc_amps_q <= 16'd1024;
			pwm_period_q <= 16'd999;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_SPEED_KP:          speed_kp_q <= cfg_data;
				REG_SPEED_KI:          speed_ki_q <= cfg_data;
				REG_CURRENT_KP:        current_kp_q <= cfg_data;
				REG_CURRENT_KI:        current_ki_q <= cfg_data;
				REG_SPEED_SCALE:       speed_scale_q <= cfg_data;
				REG_ADC_ZERO_CODE:     adc_zero_q <= cfg_data[ADC_WIDTH-1:0];
				REG_ADC_AMPS_PER_CODE: adc_amps_q <= cfg_data;
				REG_PWM_PERIOD:        pwm_period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= action;
			wheel_q <= wheel_index;
			target_q <= target_speed;
			count_q <= encoder_count;
			down_q <= counting_down;
			code_q <= adc_sample[ADC_WIDTH-1:0];
		end
	end

	assign adc_diff = $signed({1'b0, code_q}) - $signed({1'b0, adc_zero_q});

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (cmd.mul_meas) begin
			if (!action_q) begin
				mul_a = {17'd0, count_q};
				mul_b = {1'b0, speed_scale_q};
			end else begin
				mul_a = {{(32 - ADC_WIDTH){adc_diff[ADC_WIDTH]}}, adc_diff};
				mul_b = {1'b0, adc_amps_q};
			end
		end else if (cmd.mul_p) begin
			mul_a = {{8{err_q[24]}}, err_q};
			mul_b = {1'b0, action_q ? current_kp_q : speed_kp_q};
		end else if (cmd.mul_i) begin
			mul_a = {integ_q[31], integ_q};
			mul_b = {1'b0, action_q ? current_ki_q : speed_ki_q};
		end
	end

	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk) begin
		if (cmd.mul_meas || cmd.mul_p || cmd.mul_i) prod_q <= mul_p;
		if (cmd.mul_i) acc_q <= prod_q;
	end

	// measurement, error and integrator
	logic [27:0]        spd_mag;
	logic [22:0]        spd_mag_sat;
	logic signed [23:0] mspeed;
	logic signed [49:0] cur_shr;
	logic signed [23:0] mcur;
	logic signed [23:0] meas_val;
	logic signed [23:0] ref_val;
	logic signed [24:0] err_d;
	logic signed [31:0] integ_old;
	logic signed [32:0] integ_sum;
	logic signed [31:0] integ_d;

	always_comb begin
		spd_mag = prod_q[31:4];
		spd_mag_sat = (spd_mag > 28'd8388607) ? 23'h7FFFFF : spd_mag[22:0];
		mspeed = down_q ? (24'sd0 - $signed({1'b0, spd_mag_sat}))
			: $signed({1'b0, spd_mag_sat});

		cur_shr = (prod_q + (prod_q[49] ? 50'sd15 : 50'sd0)) >>> 4;
		if (cur_shr > 50'sd8388607) mcur = 24'sh7FFFFF;
		else if (cur_shr < -50'sd8388608) mcur = -24'sh800000;
		else mcur = cur_shr[23:0];

		meas_val = action_q ? mcur : mspeed;
		ref_val = action_q ? setpt_q[wheel_q] : target_q;
		err_d = {ref_val[23], ref_val} - {meas_val[23], meas_val};

		integ_old = action_q ? cur_int_q[wheel_q] : spd_int_q[wheel_q];
		integ_sum = {integ_old[31], integ_old} + {{8{err_d[24]}}, err_d};
		if (integ_sum[32] != integ_sum[31])
			integ_d = integ_sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
		else
			integ_d = integ_sum[31:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.meas) begin
			meas_q <= meas_val;
			err_q <= err_d;
			integ_q <= integ_d;
		end
	end

	// final sum, set point and duty split
	logic signed [49:0] sum;
	logic signed [49:0] spd_shr;
	logic signed [23:0] new_setpt;
	logic [49:0]        abs_sum;
	logic [29:0]        drv;
	logic [15:0]        drive;
	logic [15:0]        new_fwd, new_rev;

	always_comb begin
		sum = acc_q + prod_q;
		spd_shr = (sum + (sum[49] ? 50'sd255 : 50'sd0)) >>> 8;
		if (spd_shr > 50'sd8388607) new_setpt = 24'sh7FFFFF;
		else if (spd_shr < -50'sd8388608) new_setpt = -24'sh800000;
		else new_setpt = spd_shr[23:0];

		abs_sum = sum[49] ? 50'(-sum) : 50'(sum);
		drv = abs_sum[49:20];
		drive = (drv > {14'd0, pwm_period_q}) ? pwm_period_q : drv[15:0];
		new_fwd = sum[49] ? 16'd0 : drive;
		new_rev = sum[49] ? drive : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WHEEL_COUNT; i++) begin
				spd_int_q[i] <= '0;
				cur_int_q[i] <= '0;
				setpt_q[i] <= '0;
				duty_fwd_q[i] <= '0;
				duty_rev_q[i] <= '0;
			end
		end else if (cmd.fin && !bad) begin
			if (!action_q) begin
				spd_int_q[wheel_q] <= integ_q;
				setpt_q[wheel_q] <= new_setpt;
			end else begin
				cur_int_q[wheel_q] <= integ_q;
				duty_fwd_q[wheel_q] <= new_fwd;
				duty_rev_q[wheel_q] <= new_rev;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			out_wheel <= wheel_q;
			if (bad) begin
				measured_speed <= '0;
				measured_current <= '0;
				current_setpoint <= '0;
				duty_forward <= '0;
				duty_reverse <= '0;
			end else begin
				measured_speed <= action_q ? 24'sd0 : meas_q;
				measured_current <= action_q ? meas_q : 24'sd0;
				current_setpoint <= action_q ? setpt_q[wheel_q] : new_setpt;
				duty_forward <= action_q ? new_fwd : duty_fwd_q[wheel_q];
				duty_reverse <= action_q ? new_rev : duty_rev_q[wheel_q];
			end
		end
	end

endmodule

// ----- sv/cpmc_checker.sv -----
module cpmc_props (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [1:0]                       out_wheel,
	input logic signed [23:0]               measured_speed,
	input logic signed [23:0]               current_setpoint,
	input logic signed [23:0]               measured_current,
	input logic [15:0]                      duty_forward,
	input logic [15:0]                      duty_reverse
);
	import cpmc_pkg::*;

	// one request in flight
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another is in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_wheel)
			&& $stable(duty_forward) && $stable(duty_reverse)
			&& $stable(current_setpoint))
		else $error("stalled result changed");

	a_duty_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> duty_forward == 16'd0 || duty_reverse == 16'd0)
		else $error("both PWM channels driven");

	a_bad_wheel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && int'(out_wheel) >= WHEEL_COUNT |-> measured_speed == 24'sd0
			&& measured_current == 24'sd0 && current_setpoint == 24'sd0
			&& duty_forward == 16'd0 && duty_reverse == 16'd0)
		else $error("out-of-range wheel result not zero");

	a_one_measure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> measured_speed == 24'sd0 || measured_current == 24'sd0)
		else $error("speed and current both reported");

endmodule

bind cascaded_pi_motor_controller_top cpmc_props u_cpmc_props (.*);
